### src/angle_pid_with_wraparound_top_macros.svh
// Assertion macros for the angle PID controller.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef ANGLE_PID_WITH_WRAPAROUND_TOP_MACROS_SVH
`define ANGLE_PID_WITH_WRAPAROUND_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, masked while reset is asserted.
`define APID_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Checked property, evaluated during reset as well.
`define APID_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define APID_ASSERT(lbl, clk, rstn, prop, msg)
`define APID_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

### src/apid_pkg.sv
// Shared constants, register codes and types for the angle PID controller.
// No dependencies; used by apid_datapath and angle_pid_with_wraparound_top.
package apid_pkg;

    // Encoder geometry and fixed-point format.
    localparam int COUNTS_PER_TURN = 8192;
    localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
    localparam int FRACTION_BITS   = 8;

    // Field widths.
    localparam int ANGLE_W    = $clog2(COUNTS_PER_TURN);
    localparam int ERR_W      = ANGLE_W + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int DRIVE_W    = 16;
    localparam int PROD_W     = GAIN_W + ERR_W;
    localparam int DPROD_W    = GAIN_W + DIFF_W;
    localparam int INTEG_W    = LIM_W + FRACTION_BITS + 1;
    localparam int RAW_W      = ((PROD_W > INTEG_W) ? PROD_W : INTEG_W) + 1;
    localparam int SUM_W      = DPROD_W + 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP           = 3'd0,
        REG_KI           = 3'd1,
        REG_KD           = 3'd2,
        REG_MAX_INTEGRAL = 3'd3,
        REG_OUTPUT_LIMIT = 3'd4
    } t_cfg_reg;

    // Gains and limits as held by the configuration registers.
    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic [LIM_W-1:0]         max_integral;
        logic [LIM_W-1:0]         output_limit;
    } t_cfg;

    // Loop state carried from one sample to the next.
    typedef struct packed {
        logic signed [ERR_W-1:0]   prev_err;
        logic signed [INTEG_W-1:0] integral;
    } t_pid_state;

    // Outcome of one controller step.
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integral;
        logic signed [DRIVE_W-1:0] drive;
    } t_pid_res;

endpackage

### src/angle_pid_with_wraparound_top.sv
// Throughput: one sample per cycle while the drive output is not stalled; the input
// register, the combinational PID step (three multipliers and two clamps) and the drive
// register form a two-stage pipe. An accepted sample goes through the PID step into the
// drive register, which holds a stalled result while the next sample waits in the input
// register. Synchronous active-low reset clears gains, limits, error and integral state.
module angle_pid_with_wraparound_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [apid_pkg::ANGLE_W-1:0]         i_measured_angle,
    input  logic [apid_pkg::ANGLE_W-1:0]         i_target_angle,
    output logic                                 o_drive_valid,
    input  logic                                 i_drive_ready,
    output logic signed [apid_pkg::DRIVE_W-1:0]  o_drive,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [apid_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [apid_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import apid_pkg::*;
    `include "angle_pid_with_wraparound_top_macros.svh"

    t_cfg                      r_cfg;
    t_cfg                      n_cfg;
    t_pid_state                r_state;
    t_pid_state                n_state;
    t_pid_res                  res;
    logic                      r_in_vld;
    logic                      n_in_vld;
    logic [ANGLE_W-1:0]        r_measured;
    logic [ANGLE_W-1:0]        r_target;
    logic                      r_out_vld;
    logic                      n_out_vld;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                      in_accept;
    logic                      advance;

    // Handshake: a stage moves on when the drive register is empty or being drained.
    assign advance     = r_in_vld && (!r_out_vld || i_drive_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // The PID step itself.
    apid_datapath u_datapath (
        .i_measured_angle (r_measured),
        .i_target_angle   (r_target),
        .i_cfg            (r_cfg),
        .i_state          (r_state),
        .o_res            (res)
    );

    // Next-state logic for control, configuration and loop state.
    always_comb begin
        n_in_vld  = in_accept ? 1'b1 : (advance ? 1'b0 : r_in_vld);
        n_out_vld = advance ? 1'b1 : (i_drive_ready ? 1'b0 : r_out_vld);

        n_state = r_state;
        if (advance) begin
            n_state.prev_err = res.err;
            n_state.integral = res.integral;
        end

        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_KP:           n_cfg.kp           = $signed(i_cfg_data[GAIN_W-1:0]);
                REG_KI:           n_cfg.ki           = $signed(i_cfg_data[GAIN_W-1:0]);
                REG_KD:           n_cfg.kd           = $signed(i_cfg_data[GAIN_W-1:0]);
                REG_MAX_INTEGRAL: n_cfg.max_integral = i_cfg_data[LIM_W-1:0];
                REG_OUTPUT_LIMIT: n_cfg.output_limit = i_cfg_data[LIM_W-1:0];
                default:          n_cfg              = r_cfg;
            endcase
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
            r_cfg     <= '0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            r_state   <= n_state;
            r_cfg     <= n_cfg;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_measured <= i_measured_angle;
            r_target   <= i_target_angle;
        end
        if (advance) begin
            r_drive <= res.drive;
        end
    end

    assign o_drive_valid = r_out_vld;
    assign o_drive       = r_drive;

    // Checks on the pipeline and the arithmetic.
    `APID_ASSERT_NR(a_reset_clears, i_clk, !i_rst_n |=> (!r_in_vld && !r_out_vld && r_state == '0), "reset did not clear pipeline and loop state")
    `APID_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, !o_in_ready |-> (r_in_vld && r_out_vld), "input stalled with a free stage")
    `APID_ASSERT(a_err_wrapped, i_clk, i_rst_n, r_in_vld |-> (res.err <= ERR_W'(HALF_TURN) && res.err >= -ERR_W'(HALF_TURN)), "wrapped error outside half a turn")
    `APID_ASSERT(a_integral_clamped, i_clk, i_rst_n, r_in_vld |-> (res.integral <= $signed(INTEG_W'({r_cfg.max_integral, {FRACTION_BITS{1'b0}}})) && res.integral >= -$signed(INTEG_W'({r_cfg.max_integral, {FRACTION_BITS{1'b0}}}))), "integral outside its clamp")
    `APID_ASSERT(a_drive_limited, i_clk, i_rst_n, r_in_vld |-> (res.drive <= $signed(DRIVE_W'(r_cfg.output_limit)) && res.drive >= -$signed(DRIVE_W'(r_cfg.output_limit))), "drive outside output limit")

endmodule

### src/apid_datapath.sv
// Combinational PID step: error wrap, clamped integral, derivative and saturated drive.
// Depends on apid_pkg.
module apid_datapath (
    input  logic [apid_pkg::ANGLE_W-1:0] i_measured_angle,
    input  logic [apid_pkg::ANGLE_W-1:0] i_target_angle,
    input  apid_pkg::t_cfg               i_cfg,
    input  apid_pkg::t_pid_state         i_state,
    output apid_pkg::t_pid_res           o_res
);
    import apid_pkg::*;

    localparam logic signed [DIFF_W-1:0] HALF_S = DIFF_W'(HALF_TURN);
    localparam logic signed [DIFF_W-1:0] TURN_S = DIFF_W'(COUNTS_PER_TURN);

    logic signed [DIFF_W-1:0]  diff_raw;
    logic signed [DIFF_W-1:0]  err_wide;
    logic signed [ERR_W-1:0]   err;
    logic signed [PROD_W-1:0]  prod_i;
    logic signed [PROD_W-1:0]  prod_p;
    logic signed [DIFF_W-1:0]  err_delta;
    logic signed [DPROD_W-1:0] prod_d;
    logic signed [RAW_W-1:0]   integ_raw;
    logic signed [RAW_W-1:0]   integ_lim;
    logic signed [RAW_W-1:0]   integ_clamped;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   quot;
    logic signed [SUM_W-1:0]   out_lim;
    logic signed [SUM_W-1:0]   quot_clamped;

    // Wrap the angle difference to the short way around the circle.
    always_comb begin
        diff_raw = $signed(DIFF_W'(i_target_angle)) - $signed(DIFF_W'(i_measured_angle));
        if (diff_raw >= HALF_S) begin
            err_wide = diff_raw - TURN_S;
        end else if (diff_raw <= -HALF_S) begin
            err_wide = diff_raw + TURN_S;
        end else begin
            err_wide = diff_raw;
        end
        err = err_wide[ERR_W-1:0];
    end

    // Three independent gain products.
    assign prod_p    = i_cfg.kp * err;
    assign prod_i    = i_cfg.ki * err;
    assign err_delta = DIFF_W'(err) - DIFF_W'(i_state.prev_err);
    assign prod_d    = i_cfg.kd * err_delta;

    // Running integral, clamped to the configured magnitude.
    always_comb begin
        integ_lim = $signed(RAW_W'({i_cfg.max_integral, {FRACTION_BITS{1'b0}}}));
        integ_raw = RAW_W'(i_state.integral) + RAW_W'(prod_i);
        if (integ_raw > integ_lim) begin
            integ_clamped = integ_lim;
        end else if (integ_raw < -integ_lim) begin
            integ_clamped = -integ_lim;
        end else begin
            integ_clamped = integ_raw;
        end
    end

    // Sum of terms, floor to whole units, then saturate.
    always_comb begin
        sum     = SUM_W'(prod_p) + SUM_W'(integ_clamped) + SUM_W'(prod_d);
        quot    = sum >>> FRACTION_BITS;
        out_lim = $signed(SUM_W'(i_cfg.output_limit));
        if (quot > out_lim) begin
            quot_clamped = out_lim;
        end else if (quot < -out_lim) begin
            quot_clamped = -out_lim;
        end else begin
            quot_clamped = quot;
        end
    end

    assign o_res.err      = err;
    assign o_res.integral = integ_clamped[INTEG_W-1:0];
    assign o_res.drive    = quot_clamped[DRIVE_W-1:0];

endmodule

### tb/tb_angle_pid_with_wraparound_top.sv
// Self-checking testbench for angle_pid_with_wraparound_top: random and directed angle pairs,
// gain and limit settings, and a scoreboard that predicts each drive value in fixed point.
// Depends on apid_pkg and the RTL of angle_pid_with_wraparound_top only.
module tb_angle_pid_with_wraparound_top;
    timeunit 1ns;
    timeprecision 1ps;

    import apid_pkg::*;

    localparam int PHASE_ITEMS   = 115;
    localparam int PHASE_COUNT   = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int CFG_IDX_MAX   = (1 << CFG_IDX_W) - 1;

    // Scoreboard: shadow registers, loop state and the queue of predicted drive values.
    class drive_scoreboard;
        t_cfg    cfg;
        int      prev_err;
        longint  integral;
        int      errors;
        logic signed [DRIVE_W-1:0] pending_drive[$];

        function new();
            cfg      = '0;
            prev_err = 0;
            integral = 0;
            errors   = 0;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Apply a register write; unused indexes change nothing.
        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_KP:           cfg.kp = data;
                REG_KI:           cfg.ki = data;
                REG_KD:           cfg.kd = data;
                REG_MAX_INTEGRAL: cfg.max_integral = data[LIM_W-1:0];
                REG_OUTPUT_LIMIT: cfg.output_limit = data[LIM_W-1:0];
                default: ;
            endcase
        endfunction

        // Predict the drive value of one sample and advance the loop state.
        function void note_sample(logic [ANGLE_W-1:0] meas, logic [ANGLE_W-1:0] targ);
            int     diff;
            int     err;
            longint bound;
            longint integ;
            longint total;
            longint q;
            diff = int'(targ) - int'(meas);
            err  = diff;
            if (diff >= HALF_TURN) begin
                err = diff - COUNTS_PER_TURN;
            end else if (diff <= -HALF_TURN) begin
                err = diff + COUNTS_PER_TURN;
            end
            bound = longint'(cfg.max_integral) << FRACTION_BITS;
            integ = integral + longint'($signed(cfg.ki)) * err;
            if (integ > bound) integ = bound;
            if (integ < -bound) integ = -bound;
            integral = integ;
            total = longint'($signed(cfg.kp)) * err + integ
                  + longint'($signed(cfg.kd)) * (err - prev_err);
            // Arithmetic shift floors toward minus infinity.
            q = total >>> FRACTION_BITS;
            if (q > longint'(cfg.output_limit)) q = longint'(cfg.output_limit);
            if (q < -longint'(cfg.output_limit)) q = -longint'(cfg.output_limit);
            prev_err = err;
            pending_drive.push_back(DRIVE_W'(q));
        endfunction

        task check_drive(logic signed [DRIVE_W-1:0] got);
            logic signed [DRIVE_W-1:0] want;
            if (pending_drive.size() == 0) begin
                report_mismatch($sformatf("drive %0d with no sample outstanding", got));
            end else begin
                want = pending_drive.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("drive %0d, expected %0d", got, want));
                end
            end
        endtask

        function int pending();
            return pending_drive.size();
        endfunction
    endclass

    logic                        i_clk            = 1'b0;
    logic                        i_rst_n          = 1'b0;
    logic                        i_in_valid       = 1'b0;
    logic                        o_in_ready;
    logic [ANGLE_W-1:0]          i_measured_angle = '0;
    logic [ANGLE_W-1:0]          i_target_angle   = '0;
    logic                        o_drive_valid;
    logic                        i_drive_ready    = 1'b0;
    logic signed [DRIVE_W-1:0]   o_drive;
    logic                        i_cfg_valid      = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data       = '0;

    drive_scoreboard sb = new();
    bit  idle_en = 1'b1;
    int  cycle_count = 0;
    int  stall_left = 0;

    angle_pid_with_wraparound_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_measured_angle (i_measured_angle),
        .i_target_angle   (i_target_angle),
        .o_drive_valid    (o_drive_valid),
        .i_drive_ready    (i_drive_ready),
        .o_drive          (o_drive),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** angle_pid_with_wraparound_top: FAILED **");
            $finish;
        end
    end

    // Drive-side backpressure in short random bursts.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_drive_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 2);
            i_drive_ready <= 1'b0;
        end else begin
            i_drive_ready <= 1'b1;
        end
    end

    // Monitors: every completed transaction on each channel goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            sb.set_register(i_cfg_index, i_cfg_data);
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_sample(i_measured_angle, i_target_angle);
        end
        if (i_rst_n && o_drive_valid && i_drive_ready) begin
            sb.check_drive(o_drive);
        end
    end

    // One register write; the caller lowers valid after the last one.
    task automatic program_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
    endtask

    // Load all gains and limits, with junk in the unused top bit of the limits,
    // followed by a write to an unused index that must change nothing.
    task automatic apply_settings(int kp, int ki, int kd, int max_int, int out_lim);
        program_register(REG_KP, CFG_DATA_W'(kp));
        program_register(REG_KI, CFG_DATA_W'(ki));
        program_register(REG_KD, CFG_DATA_W'(kd));
        program_register(REG_MAX_INTEGRAL, {1'($urandom), LIM_W'(max_int)});
        program_register(REG_OUTPUT_LIMIT, {1'($urandom), LIM_W'(out_lim)});
        program_register(CFG_IDX_W'($urandom_range(int'(REG_OUTPUT_LIMIT) + 1, CFG_IDX_MAX)),
                         CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // One sample transaction, optionally preceded by a short idle gap.
    task automatic send_sample(logic [ANGLE_W-1:0] meas, logic [ANGLE_W-1:0] targ);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_measured_angle <= meas;
        i_target_angle   <= targ;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
    endtask

    // Small tracking errors so the integral builds up, as often as full-range
    // angles, plus pairs straddling the half-turn wrap point.
    task automatic send_random_sample();
        logic [ANGLE_W-1:0] meas;
        logic [ANGLE_W-1:0] targ;
        int sel;
        sel  = $urandom_range(0, 9);
        meas = ANGLE_W'($urandom);
        if (sel < 4) begin
            targ = ANGLE_W'($urandom);
        end else if (sel < 8) begin
            targ = ANGLE_W'(int'(meas) + int'($urandom_range(0, 128)) - 64);
        end else begin
            targ = ANGLE_W'(int'(meas) + HALF_TURN + int'($urandom_range(0, 4)) - 2);
        end
        send_sample(meas, targ);
    endtask

    // Let every outstanding drive value arrive, then let the pipe settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int rand_signed(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: first step after reset, angle extremes and the wrap points.
        apply_settings(256, 16, 128, 2000, 30000);
        send_sample(13'd100, 13'd164);
        send_sample('0, '0);
        send_sample('0, '1);
        send_sample('1, '0);
        send_sample('1, '1);
        send_sample('0, ANGLE_W'(HALF_TURN));
        send_sample(ANGLE_W'(HALF_TURN), '0);
        send_sample(ANGLE_W'(HALF_TURN - 1), '0);
        send_sample('0, ANGLE_W'(HALF_TURN - 1));
        send_sample(ANGLE_W'(HALF_TURN + 1), '0);
        send_sample('0, ANGLE_W'(HALF_TURN + 1));
        send_sample(13'd100, ANGLE_W'(HALF_TURN + 100));
        send_sample(ANGLE_W'(HALF_TURN + 904), 13'd904);
        send_sample(13'd1, '0);
        send_sample('0, 13'd1);
        send_sample(13'h0AAA, 13'h1555);
        send_sample(13'h1555, 13'h0AAA);
        wait_drained();

        // Random part across a series of gain and limit settings.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: apply_settings(rand_signed(2048), rand_signed(64), rand_signed(1024),
                                  $urandom_range(100, 4000), $urandom_range(1000, 32767));
                1: apply_settings(32767, 32767, 32767, 32767, 32767);
                2: apply_settings(-32768, -32768, -32768, 32767, 32767);
                3: apply_settings(rand_signed(32768), rand_signed(32768), rand_signed(32768),
                                  0, 0);
                4: apply_settings(rand_signed(1024), rand_signed(256), rand_signed(1024),
                                  0, 32767);
                5: apply_settings(rand_signed(32768), rand_signed(32768), rand_signed(32768),
                                  $urandom_range(0, 32767), $urandom_range(0, 32767));
                6: apply_settings(rand_signed(1024), rand_signed(64), rand_signed(512),
                                  $urandom_range(0, 8), $urandom_range(0, 20));
                default: apply_settings(rand_signed(2048), rand_signed(128), rand_signed(2048),
                                        $urandom_range(0, 32767), $urandom_range(0, 32767));
            endcase
            // The closing stretch runs with no gaps and no backpressure.
            if (phase == PHASE_COUNT - 1) idle_en = 1'b0;
            repeat (PHASE_ITEMS) send_random_sample();
            wait_drained();
        end

        if (sb.errors == 0) begin
            $display("** angle_pid_with_wraparound_top: PASSED **");
        end else begin
            $display("** angle_pid_with_wraparound_top: FAILED **");
        end
        $finish;
    end

endmodule

### angle_pid_with_wraparound_top.f
+incdir+src
src/apid_pkg.sv
src/apid_datapath.sv
src/angle_pid_with_wraparound_top.sv
tb/tb_angle_pid_with_wraparound_top.sv
